// ===== sv/assert_macros.svh =====
// Assertion helpers for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define VTG_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define VTG_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/vtg_pkg.sv =====
// ----------------------------------------------------------------------------
// vtg_pkg
// Types, widths and codes shared by the vertex tangent generator files.
// ----------------------------------------------------------------------------
package vtg_pkg;

  localparam int VERTEX_COUNT_DEF = 1024;
  localparam int IDX_W            = 10;
  localparam int EPS_W            = 16;
  localparam int CFG_IDX_W        = 2;
  localparam int ACC_W            = 40;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_TRI  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DET_EPS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_EPS = 2'd1;

  localparam logic [EPS_W-1:0] DET_EPS_RST = 16'd43;
  localparam logic [EPS_W-1:0] LEN_EPS_RST = 16'd1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [16:0] NEAR_ONE_X = 17'd58982;

  // divider: remainder width and quotient/dividend-tail width
  localparam int DIV_W  = 52;
  localparam int TAIL_W = 39;
  localparam int STEP_W = 6;

  // square root: radicand and root widths
  localparam int SQ_W   = 62;
  localparam int ROOT_W = 31;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [17:0] nz;
    logic signed [23:0] tu;
    logic signed [23:0] tv;
  } vertex_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] ax;
    logic signed [ACC_W-1:0] ay;
    logic signed [ACC_W-1:0] az;
  } acc_t;

endpackage

// ===== sv/vtg_if.sv =====
// ----------------------------------------------------------------------------
// vtg channel interfaces
// Command, result and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vtg_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [9:0]         vertex_index;
  logic [9:0]         second_index;
  logic [9:0]         third_index;
  logic signed [23:0] position_x;
  logic signed [23:0] position_y;
  logic signed [23:0] position_z;
  logic signed [17:0] normal_x;
  logic signed [17:0] normal_y;
  logic signed [17:0] normal_z;
  logic signed [23:0] texcoord_u;
  logic signed [23:0] texcoord_v;

  modport source (output valid, command, vertex_index, second_index, third_index,
                  position_x, position_y, position_z, normal_x, normal_y, normal_z,
                  texcoord_u, texcoord_v, input ready);
  modport sink (input valid, command, vertex_index, second_index, third_index,
                position_x, position_y, position_z, normal_x, normal_y, normal_z,
                texcoord_u, texcoord_v, output ready);
endinterface

interface vtg_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] tangent_x;
  logic signed [17:0] tangent_y;
  logic signed [17:0] tangent_z;
  logic               handedness;
  logic               used_fallback;
  logic [9:0]         read_index;

  modport source (output valid, tangent_x, tangent_y, tangent_z, handedness,
                  used_fallback, read_index, input ready);
  modport sink (input valid, tangent_x, tangent_y, tangent_z, handedness,
                used_fallback, read_index, output ready);
endinterface

interface vtg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [15:0] write_data;

  modport source (output valid, reg_index, write_data, input ready);
  modport sink (input valid, reg_index, write_data, output ready);
endinterface

// ===== sv/vtg_mem.sv =====
// ----------------------------------------------------------------------------
// vtg_mem
// Single-port-write, single-port-read synchronous memory, registered read.
// ----------------------------------------------------------------------------
module vtg_mem #(
  parameter int W     = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/vtg_div3.sv =====
// ----------------------------------------------------------------------------
// vtg_div3
// Three-lane restoring divider with a shared divisor, one quotient bit per
// cycle. Each lane starts from a given partial remainder and shifts in the
// remaining dividend bits MSB first.
// ----------------------------------------------------------------------------
module vtg_div3 (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  vtg_pkg::div_ctl_t                         ctl,
  input  logic [vtg_pkg::DIV_W-1:0]                 divisor,
  input  logic [2:0][vtg_pkg::DIV_W-1:0]            rem0,
  input  logic [2:0][vtg_pkg::TAIL_W-1:0]           tail,
  output logic                                      busy,
  output logic [2:0][vtg_pkg::TAIL_W-1:0]           quo
);

  localparam int DW = vtg_pkg::DIV_W;
  localparam int TW = vtg_pkg::TAIL_W;

  logic                      busy_r;
  logic [vtg_pkg::STEP_W-1:0] cnt_r;
  logic [DW-1:0]             dvs_r;
  logic [2:0][DW-1:0]        rem_r, rem_nxt;
  logic [2:0][TW-1:0]        tail_r;
  logic [2:0][TW-1:0]        quo_r, quo_nxt;

  always_comb begin
    logic [DW-1:0] trial;
    for (int i = 0; i < 3; i++) begin
      trial = {rem_r[i][DW-2:0], tail_r[i][TW-1]};
      if (trial >= dvs_r) begin
        rem_nxt[i] = trial - dvs_r;
        quo_nxt[i] = {quo_r[i][TW-2:0], 1'b1};
      end else begin
        rem_nxt[i] = trial;
        quo_nxt[i] = {quo_r[i][TW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      cnt_r  <= ctl.steps;
      dvs_r  <= divisor;
      rem_r  <= rem0;
      tail_r <= tail;
      quo_r  <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      for (int i = 0; i < 3; i++) begin
        tail_r[i] <= {tail_r[i][TW-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == vtg_pkg::STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

// ===== sv/vtg_isqrt.sv =====
// ----------------------------------------------------------------------------
// vtg_isqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module vtg_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [vtg_pkg::SQ_W-1:0]     x,
  output logic                         busy,
  output logic [vtg_pkg::ROOT_W-1:0]   root
);

  localparam int SW = vtg_pkg::SQ_W;
  localparam int KW = $clog2(vtg_pkg::ROOT_W);

  logic          busy_r;
  logic [KW-1:0] k_r;
  logic [SW-1:0] x_r, r_r;
  logic [SW-1:0] bit_v, trial;

  assign bit_v = SW'(1) << {k_r, 1'b0};
  assign trial = r_r + bit_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      k_r    <= KW'(vtg_pkg::ROOT_W - 1);
      x_r    <= x;
      r_r    <= '0;
    end else if (busy_r) begin
      if (x_r >= trial) begin
        x_r <= x_r - trial;
        r_r <= (r_r >> 1) + bit_v;
      end else begin
        r_r <= r_r >> 1;
      end
      k_r <= k_r - 1'b1;
      if (k_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign root = r_r[vtg_pkg::ROOT_W-1:0];

endmodule

// ===== sv/vertex_tangent_generator.sv =====
// ----------------------------------------------------------------------------
// vertex_tangent_generator
// Per-vertex tangent accumulation and Gram-Schmidt readout in fixed point.
// ----------------------------------------------------------------------------
// One command at a time. A triangle runs three vertex reads, the edge/UV
// products, 39 steps of the shared three-lane divider, then a read-modify-write
// of each corner's accumulator; it ends after the determinant check when its UV
// determinant is too small. A read runs the dot product and projection, one or
// two passes of the 31-step square root, a normalizing shifter that moves one
// bit a cycle, and 17 divider steps, then waits out any output stall. Vertex
// data and accumulators live in two synchronous memories; an accumulator entry
// is cleared when its vertex is loaded, so there is no clearing pass after
// reset. A finished result waits in the output register while the next
// command is taken.
// ----------------------------------------------------------------------------
module vertex_tangent_generator #(
  parameter int VERTEX_COUNT = vtg_pkg::VERTEX_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  vtg_in_if.sink       in_port,
  vtg_out_if.source    out_port,
  vtg_cfg_if.sink      cfg_port
);

  `include "assert_macros.svh"

  localparam int AW  = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int VW  = $bits(vtg_pkg::vertex_t);
  localparam int CW  = $bits(vtg_pkg::acc_t);
  localparam int DW  = vtg_pkg::DIV_W;
  localparam int TW  = vtg_pkg::TAIL_W;
  localparam int MW  = 47;

  typedef enum logic [5:0] {
    S_IDLE, S_TRD_A, S_TRD_B, S_TRD_C, S_TCAP, S_TDIFF, S_TMUL, S_TDET, S_TCHK,
    S_TDIV, S_TACC_RD, S_TACC_WR,
    S_RRD, S_RCAP, S_RP1, S_RP2, S_RDOT, S_RM1, S_RM2, S_RV, S_MAG, S_RCHK,
    S_RSQ, S_RSUM, S_RLEN, S_NZ, S_NSH, S_NSQ, S_NSUM, S_NLEN, S_NDIV, S_OUT
  } state_t;

  function automatic logic in_range(input logic [vtg_pkg::IDX_W-1:0] idx);
    return int'({22'd0, idx}) < VERTEX_COUNT;
  endfunction

  function automatic logic signed [vtg_pkg::ACC_W-1:0] sat_add(
      input logic signed [vtg_pkg::ACC_W-1:0] a,
      input logic signed [vtg_pkg::ACC_W-1:0] b);
    logic signed [vtg_pkg::ACC_W:0] s;
    s = (vtg_pkg::ACC_W+1)'(a) + (vtg_pkg::ACC_W+1)'(b);
    if (s > (vtg_pkg::ACC_W+1)'(vtg_pkg::ACC_MAX)) return vtg_pkg::ACC_MAX;
    if (s < (vtg_pkg::ACC_W+1)'(vtg_pkg::ACC_MIN)) return vtg_pkg::ACC_MIN;
    return s[vtg_pkg::ACC_W-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic [vtg_pkg::EPS_W-1:0] det_eps_r, len_eps_r;
  logic [1:0]                cmd_r;
  logic [AW-1:0]             ia_r, ib_r, ic_r;
  logic [vtg_pkg::IDX_W-1:0] idx_r;
  logic [1:0]                k_r;
  logic                      fb_r, zero_r;

  vtg_pkg::vertex_t va_r, vb_r, vc_r;
  logic signed [24:0] e1_r [3];
  logic signed [24:0] e2_r [3];
  logic signed [24:0] du1_r, dv1_r, du2_r, dv2_r;
  logic signed [49:0] pa_r [4];
  logic signed [49:0] pb_r [4];
  logic signed [DW-1:0] num_r [3];
  logic signed [DW-1:0] det_r;
  logic [2:0] over_r, tsgn_r;
  logic signed [vtg_pkg::ACC_W-1:0] t_r [3];

  logic signed [17:0] n_r [3];
  logic signed [vtg_pkg::ACC_W-1:0] acc_r [3];
  logic signed [40:0] pph_r [3];
  logic signed [40:0] ppl_r [3];
  logic signed [61:0] prod_r [3];
  logic signed [43:0] dot_r;
  logic signed [47:0] v_r [3];
  logic [MW-1:0] m_r [3];
  logic [59:0]   sq_r [3];

  logic                       out_valid_r;
  logic signed [17:0]         out_tx_r, out_ty_r, out_tz_r;
  logic                       out_fb_r;
  logic [vtg_pkg::IDX_W-1:0]  out_idx_r;

  // memory ports
  logic             in_acc, load_we;
  logic             vrd_en, ard_en, awr_en;
  logic [AW-1:0]    vrd_addr, ard_addr, awr_addr, corner;
  logic [VW-1:0]    vrd_data_raw;
  logic [CW-1:0]    ard_data_raw, awr_data_raw;
  vtg_pkg::vertex_t vin, vrd;
  vtg_pkg::acc_t    ard, awr;

  // shared units
  vtg_pkg::div_ctl_t   div_ctl;
  logic [DW-1:0]       div_dvs;
  logic [2:0][DW-1:0]  div_rem0;
  logic [2:0][TW-1:0]  div_tail;
  logic                div_busy;
  logic [2:0][TW-1:0]  div_quo;
  logic                sq_start, sq_busy;
  logic [vtg_pkg::SQ_W-1:0]   sq_x;
  logic [vtg_pkg::ROOT_W-1:0] sq_root;

  logic                tri_skip, m_big, m_zero, m_low;
  logic [DW-1:0]       det_mag;
  logic [DW-1:0]       num_mag [3];
  logic [16:0]         nx_mag;
  logic                out_free;

  assign in_acc  = in_port.valid && in_port.ready;
  assign load_we = in_acc && (in_port.command == vtg_pkg::CMD_LOAD) &&
                   in_range(in_port.vertex_index);
  assign out_free = !out_valid_r || out_port.ready;

  assign vin.px = in_port.position_x;
  assign vin.py = in_port.position_y;
  assign vin.pz = in_port.position_z;
  assign vin.nx = in_port.normal_x;
  assign vin.ny = in_port.normal_y;
  assign vin.nz = in_port.normal_z;
  assign vin.tu = in_port.texcoord_u;
  assign vin.tv = in_port.texcoord_v;

  assign vrd = vtg_pkg::vertex_t'(vrd_data_raw);
  assign ard = vtg_pkg::acc_t'(ard_data_raw);
  assign awr_data_raw = CW'(awr);

  always_comb begin
    case (k_r)
      2'd0:    corner = ia_r;
      2'd1:    corner = ib_r;
      default: corner = ic_r;
    endcase
  end

  always_comb begin
    vrd_en   = 1'b0;
    vrd_addr = ia_r;
    ard_en   = 1'b0;
    ard_addr = ia_r;
    unique case (state_r)
      S_TRD_A: vrd_en = 1'b1;
      S_TRD_B: begin
        vrd_en   = 1'b1;
        vrd_addr = ib_r;
      end
      S_TRD_C: begin
        vrd_en   = 1'b1;
        vrd_addr = ic_r;
      end
      S_RRD: begin
        vrd_en = 1'b1;
        ard_en = 1'b1;
      end
      S_TACC_RD: begin
        ard_en   = 1'b1;
        ard_addr = corner;
      end
      default: ;
    endcase
  end

  // accumulator write: clear on load, saturating add on a triangle corner
  always_comb begin
    awr_en   = load_we || (state_r == S_TACC_WR);
    awr_addr = corner;
    awr.ax   = sat_add(ard.ax, t_r[0]);
    awr.ay   = sat_add(ard.ay, t_r[1]);
    awr.az   = sat_add(ard.az, t_r[2]);
    if (load_we) begin
      awr_addr = AW'(in_port.vertex_index);
      awr      = '0;
    end
  end

  vtg_mem #(.W(VW), .DEPTH(VERTEX_COUNT), .AW(AW)) u_vtx_mem (
    .clk     (clk),
    .wr_en   (load_we),
    .wr_addr (AW'(in_port.vertex_index)),
    .wr_data (VW'(vin)),
    .rd_en   (vrd_en),
    .rd_addr (vrd_addr),
    .rd_data (vrd_data_raw)
  );

  vtg_mem #(.W(CW), .DEPTH(VERTEX_COUNT), .AW(AW)) u_acc_mem (
    .clk     (clk),
    .wr_en   (awr_en),
    .wr_addr (awr_addr),
    .wr_data (awr_data_raw),
    .rd_en   (ard_en),
    .rd_addr (ard_addr),
    .rd_data (ard_data_raw)
  );

  // triangle and normalization checks, divider and square-root operands
  always_comb begin
    det_mag  = det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
    tri_skip = (det_r == '0) || (det_mag < DW'(det_eps_r));
    for (int i = 0; i < 3; i++) begin
      num_mag[i] = num_r[i][DW-1] ? DW'(-num_r[i]) : DW'(num_r[i]);
    end
    nx_mag = n_r[0][17] ? 17'(-n_r[0]) : n_r[0][16:0];
    m_big  = 1'b0;
    m_low  = 1'b1;
    m_zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      m_big  = m_big || (m_r[i][MW-1:30] != '0);
      m_low  = m_low && (m_r[i][MW-1:29] == '0);
      m_zero = m_zero && (m_r[i] == '0);
    end

    div_ctl.start = 1'b0;
    div_ctl.steps = vtg_pkg::STEP_W'(TW);
    div_dvs       = det_mag;
    for (int i = 0; i < 3; i++) begin
      div_rem0[i] = num_mag[i] >> 23;
      div_tail[i] = {num_mag[i][22:0], 16'd0};
    end
    if (state_r == S_TCHK) begin
      div_ctl.start = !tri_skip;
    end else begin
      div_ctl.start = (state_r == S_NLEN) && !sq_busy;
      div_ctl.steps = vtg_pkg::STEP_W'(17);
      div_dvs       = DW'(sq_root);
      for (int i = 0; i < 3; i++) begin
        div_rem0[i] = DW'(m_r[i] >> 1);
        div_tail[i] = {m_r[i][0], {(TW-1){1'b0}}};
      end
    end

    sq_start = (state_r == S_RSUM) || (state_r == S_NSUM);
    sq_x     = vtg_pkg::SQ_W'(sq_r[0]) + vtg_pkg::SQ_W'(sq_r[1]) +
               vtg_pkg::SQ_W'(sq_r[2]);
  end

  vtg_div3 u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (div_ctl),
    .divisor (div_dvs),
    .rem0    (div_rem0),
    .tail    (div_tail),
    .busy    (div_busy),
    .quo     (div_quo)
  );

  vtg_isqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .x     (sq_x),
    .busy  (sq_busy),
    .root  (sq_root)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_port.command == vtg_pkg::CMD_TRI && in_range(in_port.vertex_index) &&
              in_range(in_port.second_index) && in_range(in_port.third_index)) begin
            state_nxt = S_TRD_A;
          end else if (in_port.command == vtg_pkg::CMD_READ &&
                       in_range(in_port.vertex_index)) begin
            state_nxt = S_RRD;
          end
        end
      end
      S_TRD_A:   state_nxt = S_TRD_B;
      S_TRD_B:   state_nxt = S_TRD_C;
      S_TRD_C:   state_nxt = S_TCAP;
      S_TCAP:    state_nxt = S_TDIFF;
      S_TDIFF:   state_nxt = S_TMUL;
      S_TMUL:    state_nxt = S_TDET;
      S_TDET:    state_nxt = S_TCHK;
      S_TCHK:    state_nxt = tri_skip ? S_IDLE : S_TDIV;
      S_TDIV:    state_nxt = div_busy ? S_TDIV : S_TACC_RD;
      S_TACC_RD: state_nxt = S_TACC_WR;
      S_TACC_WR: state_nxt = (k_r == 2'd2) ? S_IDLE : S_TACC_RD;
      S_RRD:     state_nxt = S_RCAP;
      S_RCAP:    state_nxt = S_RP1;
      S_RP1:     state_nxt = S_RP2;
      S_RP2:     state_nxt = S_RDOT;
      S_RDOT:    state_nxt = S_RM1;
      S_RM1:     state_nxt = S_RM2;
      S_RM2:     state_nxt = S_RV;
      S_RV:      state_nxt = S_MAG;
      S_MAG:     state_nxt = fb_r ? S_NZ : S_RCHK;
      S_RCHK:    state_nxt = m_big ? S_NZ : S_RSQ;
      S_RSQ:     state_nxt = S_RSUM;
      S_RSUM:    state_nxt = S_RLEN;
      S_RLEN: begin
        if (!sq_busy) begin
          state_nxt = (32'(sq_root) > 32'(len_eps_r)) ? S_NZ : S_MAG;
        end
      end
      S_NZ:      state_nxt = m_zero ? S_OUT : S_NSH;
      S_NSH:     state_nxt = (!m_big && !m_low) ? S_NSQ : S_NSH;
      S_NSQ:     state_nxt = S_NSUM;
      S_NSUM:    state_nxt = S_NLEN;
      S_NLEN:    state_nxt = sq_busy ? S_NLEN : S_NDIV;
      S_NDIV:    state_nxt = div_busy ? S_NDIV : S_OUT;
      S_OUT:     state_nxt = out_free ? S_IDLE : S_OUT;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      det_eps_r   <= vtg_pkg::DET_EPS_RST;
      len_eps_r   <= vtg_pkg::LEN_EPS_RST;
      out_valid_r <= 1'b0;
      fb_r        <= 1'b0;
      k_r         <= 2'd0;
    end else begin
      state_r <= state_nxt;

      if (cfg_port.valid) begin
        case (cfg_port.reg_index)
          vtg_pkg::REG_DET_EPS: det_eps_r <= cfg_port.write_data;
          vtg_pkg::REG_LEN_EPS: len_eps_r <= cfg_port.write_data;
          default: ;
        endcase
      end

      // drop the taken word unless a new one replaces it this cycle
      if (out_valid_r && out_port.ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r  <= in_port.command;
            ia_r   <= AW'(in_port.vertex_index);
            ib_r   <= AW'(in_port.second_index);
            ic_r   <= AW'(in_port.third_index);
            idx_r  <= in_port.vertex_index;
            fb_r   <= 1'b0;
            zero_r <= 1'b0;
            k_r    <= 2'd0;
          end
        end
        S_TRD_B: va_r <= vrd;
        S_TRD_C: vb_r <= vrd;
        S_TCAP:  vc_r <= vrd;
        S_TDIFF: begin
          e1_r[0] <= 25'(vb_r.px) - 25'(va_r.px);
          e1_r[1] <= 25'(vb_r.py) - 25'(va_r.py);
          e1_r[2] <= 25'(vb_r.pz) - 25'(va_r.pz);
          e2_r[0] <= 25'(vc_r.px) - 25'(va_r.px);
          e2_r[1] <= 25'(vc_r.py) - 25'(va_r.py);
          e2_r[2] <= 25'(vc_r.pz) - 25'(va_r.pz);
          du1_r   <= 25'(vb_r.tu) - 25'(va_r.tu);
          dv1_r   <= 25'(vb_r.tv) - 25'(va_r.tv);
          du2_r   <= 25'(vc_r.tu) - 25'(va_r.tu);
          dv2_r   <= 25'(vc_r.tv) - 25'(va_r.tv);
        end
        S_TMUL: begin
          for (int i = 0; i < 3; i++) begin
            pa_r[i] <= e1_r[i] * dv2_r;
            pb_r[i] <= e2_r[i] * dv1_r;
          end
          pa_r[3] <= du1_r * dv2_r;
          pb_r[3] <= du2_r * dv1_r;
        end
        S_TDET: begin
          for (int i = 0; i < 3; i++) begin
            num_r[i] <= DW'(pa_r[i]) - DW'(pb_r[i]);
          end
          det_r <= DW'(pa_r[3]) - DW'(pb_r[3]);
        end
        S_TCHK: begin
          for (int i = 0; i < 3; i++) begin
            over_r[i] <= (num_mag[i] >> 23) >= det_mag;
            tsgn_r[i] <= num_r[i][DW-1] ^ det_r[DW-1];
          end
        end
        S_TDIV: begin
          if (!div_busy) begin
            for (int i = 0; i < 3; i++) begin
              if (over_r[i]) begin
                t_r[i] <= tsgn_r[i] ? -vtg_pkg::ACC_MAX : vtg_pkg::ACC_MAX;
              end else begin
                t_r[i] <= tsgn_r[i] ? -$signed({1'b0, div_quo[i]})
                                    : $signed({1'b0, div_quo[i]});
              end
            end
          end
        end
        S_TACC_WR: k_r <= k_r + 2'd1;
        S_RCAP: begin
          n_r[0]   <= vrd.nx;
          n_r[1]   <= vrd.ny;
          n_r[2]   <= vrd.nz;
          acc_r[0] <= ard.ax;
          acc_r[1] <= ard.ay;
          acc_r[2] <= ard.az;
        end
        S_RP1: begin
          for (int i = 0; i < 3; i++) begin
            pph_r[i] <= n_r[i] * $signed(acc_r[i][39:20]);
            ppl_r[i] <= n_r[i] * $signed({1'b0, acc_r[i][19:0]});
          end
        end
        S_RP2, S_RM2: begin
          for (int i = 0; i < 3; i++) begin
            if (state_r == S_RP2) begin
              prod_r[i] <= (62'(pph_r[i]) <<< 20) + 62'(ppl_r[i]);
            end else begin
              prod_r[i] <= (62'(pph_r[i]) <<< 22) + 62'(ppl_r[i]);
            end
          end
        end
        S_RDOT: dot_r <= 44'((prod_r[0] + prod_r[1] + prod_r[2]) >>> 16);
        S_RM1: begin
          for (int i = 0; i < 3; i++) begin
            pph_r[i] <= n_r[i] * $signed(dot_r[43:22]);
            ppl_r[i] <= n_r[i] * $signed({1'b0, dot_r[21:0]});
          end
        end
        S_RV: begin
          for (int i = 0; i < 3; i++) begin
            v_r[i] <= 48'(acc_r[i]) - 48'(prod_r[i] >>> 16);
          end
        end
        S_MAG: begin
          for (int i = 0; i < 3; i++) begin
            m_r[i] <= v_r[i][47] ? MW'(-v_r[i]) : MW'(v_r[i]);
          end
        end
        S_RSQ, S_NSQ: begin
          for (int i = 0; i < 3; i++) begin
            sq_r[i] <= m_r[i][29:0] * m_r[i][29:0];
          end
        end
        S_RLEN: begin
          // too short: swap in a vector perpendicular to the normal
          if (!sq_busy && !(32'(sq_root) > 32'(len_eps_r))) begin
            fb_r <= 1'b1;
            if (nx_mag <= vtg_pkg::NEAR_ONE_X) begin
              v_r[0] <= '0;
              v_r[1] <= 48'(n_r[2]);
              v_r[2] <= -48'(n_r[1]);
            end else begin
              v_r[0] <= -48'(n_r[2]);
              v_r[1] <= '0;
              v_r[2] <= 48'(n_r[0]);
            end
          end
        end
        S_NZ: zero_r <= m_zero;
        S_NSH: begin
          for (int i = 0; i < 3; i++) begin
            if (m_big) begin
              m_r[i] <= m_r[i] >> 1;
            end else if (m_low) begin
              m_r[i] <= m_r[i] << 1;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_fb_r    <= fb_r;
            out_idx_r   <= idx_r;
            out_tx_r    <= zero_r ? 18'sd0 : (v_r[0][47] ? -$signed({1'b0, div_quo[0][16:0]})
                                                         : $signed({1'b0, div_quo[0][16:0]}));
            out_ty_r    <= zero_r ? 18'sd0 : (v_r[1][47] ? -$signed({1'b0, div_quo[1][16:0]})
                                                         : $signed({1'b0, div_quo[1][16:0]}));
            out_tz_r    <= zero_r ? 18'sd0 : (v_r[2][47] ? -$signed({1'b0, div_quo[2][16:0]})
                                                         : $signed({1'b0, div_quo[2][16:0]}));
          end
        end
        default: ;
      endcase
    end
  end

  assign in_port.ready          = (state_r == S_IDLE);
  assign cfg_port.ready         = 1'b1;
  assign out_port.valid         = out_valid_r;
  assign out_port.tangent_x     = out_tx_r;
  assign out_port.tangent_y     = out_ty_r;
  assign out_port.tangent_z     = out_tz_r;
  assign out_port.handedness    = 1'b1;
  assign out_port.used_fallback = out_fb_r;
  assign out_port.read_index    = out_idx_r;

  `VTG_ASSERT_IMP(a_result_from_read, $rose(out_valid_r), cmd_r == vtg_pkg::CMD_READ)
  `VTG_ASSERT_IMP(a_div_start_idle, div_ctl.start, !div_busy)
  `VTG_ASSERT_IMP(a_norm_root_range, (state_r == S_NLEN) && !sq_busy, sq_root[30:29] != 2'b00)
  `VTG_ASSERT_NXT(a_tri_ends_idle, (state_r == S_TACC_WR) && (k_r == 2'd2), state_r == S_IDLE)

endmodule

// ===== tb/vertex_tangent_generator_tb.sv =====
// ----------------------------------------------------------------------------
// vertex_tangent_generator testbench
// Drives vertex loads, triangle accumulations and tangent reads through the
// command channel. A fixed-point model of the vertex table predicts all but
// one directed tangent; results are compared field by field in order.
// ----------------------------------------------------------------------------
module vertex_tangent_generator_tb;

  localparam int NV        = 1024;
  localparam int N_RANDOM  = 1300;
  localparam longint LIMIT = 2000000;
  localparam longint SAT_P = 64'sd549755813887;
  localparam longint SAT_N = -64'sd549755813888;

  localparam logic [1:0] C_LOAD = vtg_pkg::CMD_LOAD;
  localparam logic [1:0] C_TRI  = vtg_pkg::CMD_TRI;
  localparam logic [1:0] C_READ = vtg_pkg::CMD_READ;
  // unused command code, ignored by the block
  localparam logic [1:0] C_BAD  = 2'd3;

  typedef struct {
    logic [1:0]  cmd;
    logic [9:0]  a, b, c;
    logic signed [23:0] px, py, pz;
    logic signed [17:0] nx, ny, nz;
    logic signed [23:0] u, v;
  } cmd_word_t;

  typedef struct {
    logic signed [17:0] tx, ty, tz;
    logic        fb;
    logic [9:0]  idx;
  } tangent_t;

  logic clk;
  logic rst_n;

  vtg_in_if  in_port();
  vtg_out_if out_port();
  vtg_cfg_if cfg_port();

  vertex_tangent_generator i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_port  (in_port),
    .out_port (out_port),
    .cfg_port (cfg_port)
  );

  // local copy of the block's state
  longint      vpos [NV][3];
  longint      vnrm [NV][3];
  longint      vtex [NV][2];
  longint      vacc [NV][3];
  bit          loaded [NV];
  longint      det_eps;
  longint      len_eps;

  tangent_t    pending_tangents[$];
  int          errors;
  longint      cycle;
  bit          stim_done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic longint mag(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint fshift(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint isqrt64(longint x);
    longint r, bitv;
    r = 0;
    bitv = 64'sd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // trunc(num * 2^16 / den) with magnitude saturation; num fits in 64 bits
  function automatic longint tangent_quot(longint num, longint den);
    logic [127:0] nm, q;
    logic [63:0]  dm;
    longint res;
    nm = mag(num);
    dm = mag(den);
    q = (nm << 16) / dm;
    res = (q > SAT_P) ? SAT_P : longint'(q);
    return ((num < 0) != (den < 0)) ? -res : res;
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    longint s;
    s = a + b;
    if (s > SAT_P) return SAT_P;
    if (s < SAT_N) return SAT_N;
    return s;
  endfunction

  function automatic void normalize(longint v[3], output longint o[3]);
    longint m[3];
    longint mx, len;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      o = '{0, 0, 0};
      return;
    end
    while (mx >= (64'sd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (mx < (64'sd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    len = isqrt64(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++)
      o[i] = v[i] < 0 ? -((m[i] << 16) / len) : (m[i] << 16) / len;
  endfunction

  // advance the model by one command word; return 1 with a tangent on reads
  function automatic bit tangent_update(cmd_word_t w, output tangent_t t);
    longint e1[3], e2[3], tv[3], n[3], acc[3], r[3], o[3];
    longint du1, dv1, du2, dv2, det, dot, mx;
    bit long_ok;
    t = '{default: '0};
    case (w.cmd)
      C_LOAD: begin
        vpos[w.a] = '{w.px, w.py, w.pz};
        vnrm[w.a] = '{w.nx, w.ny, w.nz};
        vtex[w.a] = '{w.u, w.v};
        vacc[w.a] = '{0, 0, 0};
        loaded[w.a] = 1'b1;
        return 1'b0;
      end
      C_TRI: begin
        for (int i = 0; i < 3; i++) begin
          e1[i] = vpos[w.b][i] - vpos[w.a][i];
          e2[i] = vpos[w.c][i] - vpos[w.a][i];
        end
        du1 = vtex[w.b][0] - vtex[w.a][0];
        dv1 = vtex[w.b][1] - vtex[w.a][1];
        du2 = vtex[w.c][0] - vtex[w.a][0];
        dv2 = vtex[w.c][1] - vtex[w.a][1];
        det = du1 * dv2 - du2 * dv1;
        if (det == 0 || mag(det) < det_eps) return 1'b0;
        for (int i = 0; i < 3; i++)
          tv[i] = tangent_quot(e1[i] * dv2 - e2[i] * dv1, det);
        for (int i = 0; i < 3; i++) begin
          vacc[w.a][i] = sat_sum(vacc[w.a][i], tv[i]);
          vacc[w.b][i] = sat_sum(vacc[w.b][i], tv[i]);
          vacc[w.c][i] = sat_sum(vacc[w.c][i], tv[i]);
        end
        return 1'b0;
      end
      C_READ: begin
        n = vnrm[w.a];
        acc = vacc[w.a];
        dot = fshift(n[0] * acc[0] + n[1] * acc[1] + n[2] * acc[2], 16);
        mx = 0;
        for (int i = 0; i < 3; i++) begin
          r[i] = acc[i] - fshift(n[i] * dot, 16);
          if (mag(r[i]) > mx) mx = mag(r[i]);
        end
        long_ok = (mx >= (64'sd1 << 30)) ||
                  (isqrt64(r[0] * r[0] + r[1] * r[1] + r[2] * r[2]) > len_eps);
        t.fb = !long_ok;
        if (!long_ok) begin
          if (mag(n[0]) <= vtg_pkg::NEAR_ONE_X) r = '{0, n[2], -n[1]};
          else r = '{-n[2], 0, n[0]};
        end
        normalize(r, o);
        t.tx = o[0];
        t.ty = o[1];
        t.tz = o[2];
        t.idx = w.a;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp_v);
    $display("mismatch %s: got %0d, expected %0d (cycle %0d)", what, got, exp_v, cycle);
    errors++;
  endtask

  // receiver: stall on a shifting pattern, check against the oldest tangent
  logic [15:0] stall_pat;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_port.ready <= 1'b0;
      stall_pat <= 16'hA5C3;
    end else begin
      stall_pat <= {stall_pat[14:0], stall_pat[15] ^ stall_pat[13] ^ stall_pat[12]
                    ^ stall_pat[10]};
      out_port.ready <= (cycle % 4000 < 1000) ? 1'b1 : (stall_pat[2:0] != 3'b000);
      if (out_port.valid && out_port.ready) begin
        if (pending_tangents.size() == 0) begin
          report_mismatch("unexpected word, read_index", out_port.read_index, -1);
        end else begin
          tangent_t e;
          e = pending_tangents.pop_front();
          if (out_port.tangent_x !== e.tx) report_mismatch("tangent_x", out_port.tangent_x, e.tx);
          if (out_port.tangent_y !== e.ty) report_mismatch("tangent_y", out_port.tangent_y, e.ty);
          if (out_port.tangent_z !== e.tz) report_mismatch("tangent_z", out_port.tangent_z, e.tz);
          if (out_port.handedness !== 1'b1) report_mismatch("handedness", out_port.handedness, 1);
          if (out_port.used_fallback !== e.fb)
            report_mismatch("used_fallback", out_port.used_fallback, e.fb);
          if (out_port.read_index !== e.idx)
            report_mismatch("read_index", out_port.read_index, e.idx);
        end
      end
    end
  end

  int gap_left;
  int burst_left;

  // hold one word until accepted, with random gaps between bursts
  task automatic send_word(cmd_word_t w);
    tangent_t t;
    while (gap_left > 0) begin
      in_port.valid <= 1'b0;
      gap_left--;
      @(posedge clk);
    end
    in_port.valid        <= 1'b1;
    in_port.command      <= w.cmd;
    in_port.vertex_index <= w.a;
    in_port.second_index <= w.b;
    in_port.third_index  <= w.c;
    in_port.position_x   <= w.px;
    in_port.position_y   <= w.py;
    in_port.position_z   <= w.pz;
    in_port.normal_x     <= w.nx;
    in_port.normal_y     <= w.ny;
    in_port.normal_z     <= w.nz;
    in_port.texcoord_u   <= w.u;
    in_port.texcoord_v   <= w.v;
    do @(posedge clk); while (!in_port.ready);
    if (tangent_update(w, t)) pending_tangents = {pending_tangents, t};
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
    end
  endtask

  task automatic drain();
    in_port.valid <= 1'b0;
    while (pending_tangents.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_port.valid      <= 1'b1;
    cfg_port.reg_index  <= idx;
    cfg_port.write_data <= data;
    do @(posedge clk); while (!cfg_port.ready);
    cfg_port.valid <= 1'b0;
    if (idx == vtg_pkg::REG_DET_EPS) det_eps = data;
    else if (idx == vtg_pkg::REG_LEN_EPS) len_eps = data;
  endtask

  function automatic logic signed [17:0] rand_normal();
    case ($urandom_range(0, 5))
      0: return 18'sd65536;
      1: return -18'sd65536;
      2: return 18'sd0;
      default: return $signed(18'($urandom_range(0, 131072))) - 18'sd65536;
    endcase
  endfunction

  function automatic logic signed [23:0] rand_coord(bit wide);
    if (wide) return 24'($urandom);
    return $signed(24'($urandom_range(0, 1 << 19))) - 24'sd262144;
  endfunction

  function automatic cmd_word_t load_word(logic [9:0] idx, bit wide);
    cmd_word_t w;
    w = '{default: '0};
    w.cmd = C_LOAD;
    w.a = idx;
    w.px = rand_coord(wide);
    w.py = rand_coord(wide);
    w.pz = rand_coord(wide);
    w.nx = rand_normal();
    w.ny = rand_normal();
    w.nz = rand_normal();
    w.u = rand_coord(wide);
    w.v = rand_coord(wide);
    w.b = 10'($urandom);
    w.c = 10'($urandom);
    return w;
  endfunction

  function automatic logic [9:0] pick_loaded(logic [9:0] base);
    logic [9:0] k;
    k = base + 10'($urandom_range(0, 15));
    return loaded[k] ? k : base;
  endfunction

  // directed rows; tangent fields checked by the model
  cmd_word_t directed[] = '{
    '{C_LOAD, 10'd0, 10'd0, 10'd0, 24'sd0, 24'sd0, 24'sd0,
      18'sd0, 18'sd0, 18'sd65536, 24'sd0, 24'sd0},
    '{C_LOAD, 10'd1, 10'd0, 10'd0, 24'sd65536, 24'sd0, 24'sd0,
      18'sd0, 18'sd0, 18'sd65536, 24'sd65536, 24'sd0},
    '{C_LOAD, 10'd2, 10'd0, 10'd0, 24'sd0, 24'sd65536, 24'sd0,
      18'sd0, 18'sd0, 18'sd65536, 24'sd0, 24'sd65536},
    '{C_READ, 10'd0, 10'd0, 10'd0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{C_TRI,  10'd0, 10'd1, 10'd2, 0, 0, 0, 0, 0, 0, 0, 0},
    '{C_READ, 10'd0, 10'd0, 10'd0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{C_READ, 10'd2, 10'd0, 10'd0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{C_TRI,  10'd1, 10'd1, 10'd2, 0, 0, 0, 0, 0, 0, 0, 0},
    '{C_TRI,  10'd0, 10'd1, 10'd1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{C_BAD,  10'd0, 10'd1, 10'd2, 0, 0, 0, 0, 0, 0, 0, 0},
    '{C_LOAD, 10'd1023, 10'd1023, 10'd1023, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
      -18'sd65536, 18'sd0, 18'sd0, 24'sh7FFFFF, 24'sh800000},
    '{C_LOAD, 10'd1022, 10'd0, 10'd0, 24'sh800000, 24'sh800000, 24'sh800000,
      18'sd65536, 18'sd0, 18'sd0, 24'sh800000, 24'sh800000},
    '{C_LOAD, 10'd1021, 10'd0, 10'd0, 24'sh800000, 24'sh7FFFFF, 24'sd0,
      18'sd46341, 18'sd46341, 18'sd0, 24'sh7FFFFF, 24'sh7FFFFF},
    '{C_TRI,  10'd1023, 10'd1022, 10'd1021, 0, 0, 0, 0, 0, 0, 0, 0},
    '{C_TRI,  10'd1021, 10'd1022, 10'd1023, 0, 0, 0, 0, 0, 0, 0, 0},
    '{C_READ, 10'd1023, 10'd0, 10'd0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{C_READ, 10'd1022, 10'd0, 10'd0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{C_READ, 10'd1021, 10'd0, 10'd0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{C_TRI,  10'd0, 10'd1023, 10'd1022, 0, 0, 0, 0, 0, 0, 0, 0},
    '{C_READ, 10'd0, 10'd0, 10'd0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{C_READ, 10'd1, 10'd0, 10'd0, 0, 0, 0, 0, 0, 0, 0, 0}
  };

  initial begin
    cmd_word_t w;
    int reads;
    logic [9:0] base;
    logic [15:0] det_set[4];
    logic [15:0] len_set[4];
    tangent_t t0;
    errors = 0;
    cycle = 0;
    stim_done = 1'b0;
    gap_left = 0;
    burst_left = 0;
    det_eps = vtg_pkg::DET_EPS_RST;
    len_eps = vtg_pkg::LEN_EPS_RST;
    foreach (loaded[k]) loaded[k] = 1'b0;
    rst_n = 1'b0;
    in_port.valid = 1'b0;
    in_port.command = C_LOAD;
    in_port.vertex_index = '0;
    in_port.second_index = '0;
    in_port.third_index = '0;
    in_port.position_x = '0;
    in_port.position_y = '0;
    in_port.position_z = '0;
    in_port.normal_x = '0;
    in_port.normal_y = '0;
    in_port.normal_z = '0;
    in_port.texcoord_u = '0;
    in_port.texcoord_v = '0;
    cfg_port.valid = 1'b0;
    cfg_port.reg_index = vtg_pkg::REG_DET_EPS;
    cfg_port.write_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows at reset settings; first read of an untouched accumulator
    // with +Z normal must give the fallback (0, 1, 0)
    t0 = '{18'sd0, 18'sd65536, 18'sd0, 1'b1, 10'd0};
    foreach (directed[r]) begin
      send_word(directed[r]);
      if (r == 3) pending_tangents[pending_tangents.size() - 1] = t0;
    end
    drain();

    det_set = '{16'd0, 16'd65535, 16'd43, 16'd1000};
    len_set = '{16'd0, 16'd65535, 16'd1, 16'd300};
    reads = 0;
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(vtg_pkg::REG_DET_EPS, det_set[ph]);
      write_reg(vtg_pkg::REG_LEN_EPS, len_set[ph]);
      for (int n = 0; n < N_RANDOM / 4; ) begin
        base = 10'($urandom_range(0, 63)) << 4;
        // mesh patch: load corners, accumulate, read back
        for (int k = 0; k < 4; k++) begin
          send_word(load_word(base + 10'(k), $urandom_range(0, 7) == 0));
          n++;
        end
        repeat ($urandom_range(1, 4)) begin
          w = '{default: '0};
          w.cmd = C_TRI;
          w.a = pick_loaded(base);
          w.b = pick_loaded(base);
          w.c = pick_loaded(base);
          w.px = rand_coord(1);
          w.nx = rand_normal();
          send_word(w);
          n++;
        end
        repeat ($urandom_range(1, 3)) begin
          w = '{default: '0};
          w.cmd = C_READ;
          w.a = pick_loaded(base);
          w.b = 10'($urandom);
          w.c = 10'($urandom);
          send_word(w);
          n++;
          reads++;
        end
        if ($urandom_range(0, 9) == 0) begin
          w = load_word(10'($urandom), 1);
          w.cmd = C_BAD;
          send_word(w);
        end
      end
      drain();
    end
    write_reg(vtg_pkg::REG_DET_EPS, vtg_pkg::DET_EPS_RST);
    write_reg(vtg_pkg::REG_LEN_EPS, vtg_pkg::LEN_EPS_RST);
    stim_done = 1'b1;
    drain();
    if (errors == 0 && pending_tangents.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
